// ===== hw/rtl/owts_pkg.sv =====
package owts_pkg;

  localparam logic [7:0] OLD_FAMILY = 8'h10;
  localparam logic [7:0] CRC_POLY   = 8'h8C;
  localparam logic [3:0] LAST_POS   = 4'd8;

  localparam logic signed [15:0] VALID_LOW_RESET  = -16'sd550;
  localparam logic signed [15:0] VALID_HIGH_RESET = 16'sd1250;

  localparam logic [15:0] OLD_BIAS   = 16'd12;
  localparam logic [15:0] MASK_RES9  = 16'hFFF8;
  localparam logic [15:0] MASK_RES10 = 16'hFFFC;
  localparam logic [15:0] MASK_RES11 = 16'hFFFE;

  // tenths = (raw*625 + 500) / 1000, done as ((|x| >> 3) * RECIP) >> RECIP_SHIFT
  localparam logic signed [25:0] SCALE       = 26'sd625;
  localparam logic signed [25:0] ROUND       = 26'sd500;
  localparam logic [22:0]        RECIP       = 23'd4294968;
  localparam int                 RECIP_SHIFT = 29;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_CRC   = 2'd1,
    STATUS_FAULT = 2'd2,
    STATUS_RANGE = 2'd3
  } owts_status_t;

  typedef enum logic {
    REG_VALID_LOW  = 1'b0,
    REG_VALID_HIGH = 1'b1
  } owts_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] family_code;
    logic       bus_fault;
  } owts_in_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    owts_status_t       status;
  } owts_out_t;

  // completed frame handed to the conversion pipe
  typedef struct packed {
    logic signed [15:0] raw;
    owts_status_t       status;
    logic               check;   // status still open, range check decides
  } owts_frame_t;

  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/owts_tenths.sv =====
module owts_tenths (
  input  logic                      clk,
  input  logic                      rst,
  input  owts_pkg::owts_frame_t     frame,
  input  logic                      frame_valid,
  output logic                      frame_ready,
  input  logic signed [15:0]        valid_low,
  input  logic signed [15:0]        valid_high,
  output logic                      result_valid,
  input  logic                      result_stall,
  output owts_pkg::owts_out_t       result
);

  localparam int MagW  = 22;
  localparam int ProdW = MagW + 23;

  owts_pkg::owts_frame_t s1;
  logic                  s1_valid;

  logic signed [25:0]    s2_scaled;
  owts_pkg::owts_status_t s2_status;
  logic                  s2_check;
  logic                  s2_valid;

  logic [MagW-1:0]       s3_mag;
  logic                  s3_neg;
  owts_pkg::owts_status_t s3_status;
  logic                  s3_check;
  logic                  s3_valid;

  logic [ProdW-1:0]      s4_prod;
  logic                  s4_neg;
  owts_pkg::owts_status_t s4_status;
  logic                  s4_check;
  logic                  s4_valid;

  logic rdy_out, rdy4, rdy3, rdy2, rdy1;

  logic signed [25:0] raw_ext;
  logic        [25:0] mag_full;
  logic        [15:0] quot;
  logic signed [15:0] temp;
  logic               in_range;

  // a stage takes a new beat when it is empty or its content moves on
  assign rdy_out     = !result_valid || !result_stall;
  assign rdy4        = !s4_valid || rdy_out;
  assign rdy3        = !s3_valid || rdy4;
  assign rdy2        = !s2_valid || rdy3;
  assign rdy1        = !s1_valid || rdy2;
  assign frame_ready = rdy1;

  assign raw_ext  = 26'(s1.raw);
  assign mag_full = s2_scaled[25] ? 26'(-s2_scaled) : 26'(s2_scaled);
  assign quot     = s4_prod[ProdW-1:owts_pkg::RECIP_SHIFT];
  assign temp     = s4_neg ? $signed(16'(-quot)) : $signed(quot);
  assign in_range = (temp >= valid_low) && (temp <= valid_high);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rdy1) s1_valid <= frame_valid;
      if (rdy2) s2_valid <= s1_valid;
      if (rdy3) s3_valid <= s2_valid;
      if (rdy4) s4_valid <= s3_valid;
      if (rdy_out) result_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && frame_valid) begin
      s1 <= frame;
    end
    if (rdy2 && s1_valid) begin
      s2_scaled <= raw_ext * owts_pkg::SCALE + owts_pkg::ROUND;
      s2_status <= s1.status;
      s2_check  <= s1.check;
    end
    if (rdy3 && s2_valid) begin
      s3_mag    <= mag_full[24:3];
      s3_neg    <= s2_scaled[25];
      s3_status <= s2_status;
      s3_check  <= s2_check;
    end
    if (rdy4 && s3_valid) begin
      s4_prod   <= ProdW'(s3_mag) * ProdW'(owts_pkg::RECIP);
      s4_neg    <= s3_neg;
      s4_status <= s3_status;
      s4_check  <= s3_check;
    end
    if (rdy_out && s4_valid) begin
      if (s4_check && in_range) begin
        result.temperature <= temp;
        result.status      <= owts_pkg::STATUS_OK;
      end else begin
        result.temperature <= '0;
        result.status      <= s4_check ? owts_pkg::STATUS_RANGE : s4_status;
      end
    end
  end

endmodule

// ===== hw/rtl/onewire_temp_scratchpad_decoder.sv =====
// Scratchpad decoder: one byte beat per cycle unless item_stall holds the
// ninth byte; bytes 0..7 give no result. Once its ninth byte is taken, a
// frame goes through registers (input, constant multiply, magnitude,
// reciprocal multiply, range check); a new frame can follow back to back.
// rst is synchronous: clears byte position, CRC, fault flag and pipe valids,
// and sets the window to -55.0 .. 125.0 degrees.
module onewire_temp_scratchpad_decoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  owts_pkg::owts_in_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output owts_pkg::owts_out_t  result,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data
);

  logic [3:0]  byte_position;
  logic [7:0]  crc_running;
  logic [7:0]  temp_low_byte;
  logic [7:0]  temp_high_byte;
  logic [7:0]  config_byte;
  logic [7:0]  count_remain_byte;
  logic        fault_seen;
  logic signed [15:0] valid_low;
  logic signed [15:0] valid_high;

  logic                  accept;
  logic                  last;
  logic                  conv_ready;
  logic [15:0]           raw_word;
  logic [15:0]           raw_adj;
  owts_pkg::owts_frame_t frame;

  assign last       = byte_position >= owts_pkg::LAST_POS;
  assign item_stall = last && !conv_ready;
  assign accept     = item_valid && !item_stall;

  assign raw_word = {temp_high_byte, temp_low_byte};

  always_comb begin
    if (item.family_code == owts_pkg::OLD_FAMILY) begin
      raw_adj = {raw_word[12:0], 3'b000} + owts_pkg::OLD_BIAS - {8'h00, count_remain_byte};
    end else begin
      unique case (config_byte[6:5])
        2'd0:    raw_adj = raw_word & owts_pkg::MASK_RES9;
        2'd1:    raw_adj = raw_word & owts_pkg::MASK_RES10;
        2'd2:    raw_adj = raw_word & owts_pkg::MASK_RES11;
        default: raw_adj = raw_word;
      endcase
    end
  end

  always_comb begin
    frame.raw = $signed(raw_adj);
    if (fault_seen || item.bus_fault) begin
      frame.status = owts_pkg::STATUS_FAULT;
      frame.check  = 1'b0;
    end else if (crc_running != item.data_byte) begin
      frame.status = owts_pkg::STATUS_CRC;
      frame.check  = 1'b0;
    end else begin
      frame.status = owts_pkg::STATUS_OK;
      frame.check  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      crc_running       <= '0;
      fault_seen        <= 1'b0;
      temp_low_byte     <= '0;
      temp_high_byte    <= '0;
      config_byte       <= '0;
      count_remain_byte <= '0;
      valid_low         <= owts_pkg::VALID_LOW_RESET;
      valid_high        <= owts_pkg::VALID_HIGH_RESET;
    end else begin
      if (cfg_we) begin
        unique case (owts_pkg::owts_reg_t'(cfg_index))
          owts_pkg::REG_VALID_LOW:  valid_low  <= $signed(cfg_data);
          owts_pkg::REG_VALID_HIGH: valid_high <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (accept) begin
        if (last) begin
          byte_position <= '0;
          crc_running   <= '0;
          fault_seen    <= 1'b0;
        end else begin
          unique case (byte_position)
            4'd0:    temp_low_byte     <= item.data_byte;
            4'd1:    temp_high_byte    <= item.data_byte;
            4'd4:    config_byte       <= item.data_byte;
            4'd7:    count_remain_byte <= item.data_byte;
            default: ;
          endcase
          crc_running   <= owts_pkg::crc_update(crc_running, item.data_byte);
          byte_position <= byte_position + 4'd1;
          if (item.bus_fault) fault_seen <= 1'b1;
        end
      end
    end
  end

  owts_tenths u_tenths (
    .clk          (clk),
    .rst          (rst),
    .frame        (frame),
    .frame_valid  (accept && last),
    .frame_ready  (conv_ready),
    .valid_low    (valid_low),
    .valid_high   (valid_high),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> byte_position == '0 && crc_running == '0 && !fault_seen)
    else $error("frame state not cleared after ninth byte");

  a_stall_only_at_end: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> last)
    else $error("byte stalled before end of frame");

  a_zero_unless_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status == owts_pkg::STATUS_OK || result.temperature == '0)
    else $error("nonzero temperature with bad status");

endmodule
